/* src/kgsr_pkg.sv */
// Shared types and constants for the k-group stream reverser.
package kgsr_pkg;

   localparam int VALUE_W     = 32;
   localparam int GSIZE_W     = 5;
   // Wide enough for a run count at the largest supported group bound (256).
   localparam int CNT_MAX_W   = 9;
   localparam logic [GSIZE_W-1:0] GSIZE_RESET = 5'd2;

   // One flushed group, handed from the front end to the back end.
   typedef struct packed {
      logic                 bank;
      logic [CNT_MAX_W-1:0] count;
      logic                 reverse;
      logic                 list_end;
   } cmd_type;

   // Back end hands a buffer bank back to the front end.
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   // One result waiting in the output skid queue.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               run_last;
      logic               list_end;
   } rsp_type;

endpackage

/* src/kgsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kgsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/kgsr_front.sv */
// Front end: accepts list elements, fills a buffer bank and flushes groups.
module kgsr_front #(
   parameter int MAX_GROUP = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [kgsr_pkg::GSIZE_W-1:0]          csr_group_size,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [kgsr_pkg::VALUE_W-1:0]   req_item_value,
   input  logic                                  req_list_end,
   output logic                                  wr_en,
   output logic [$clog2(MAX_GROUP):0]            wr_addr,
   output logic [kgsr_pkg::VALUE_W-1:0]          wr_data,
   output logic                                  cmd_push,
   output kgsr_pkg::cmd_type                     cmd,
   input  kgsr_pkg::release_type                 rel
);
   import kgsr_pkg::*;

   localparam int IDX_W = $clog2(MAX_GROUP);
   localparam int CNT_W = $clog2(MAX_GROUP + 1);
   localparam int KW    = (CNT_W > GSIZE_W) ? CNT_W : GSIZE_W;

   logic [GSIZE_W-1:0] gsize_ff;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               bank_ff, bank_in;
   logic [1:0]         busy_ff, busy_in;
   logic [KW-1:0]      k_raw, k_eff;
   logic [CNT_W-1:0]   count_next;
   logic               reach, accept;

   always_comb begin
      k_raw = KW'(gsize_ff);
      priority if (k_raw == '0) begin
         k_eff = KW'(1);
      end else if (k_raw > KW'(MAX_GROUP)) begin
         k_eff = KW'(MAX_GROUP);
      end else begin
         k_eff = k_raw;
      end

      count_next = fill_ff + CNT_W'(1);
      reach      = KW'(count_next) >= k_eff;

      // Hold off while the bank to be filled is still draining.
      req_stall = busy_ff[bank_ff];
      accept    = req_valid && !req_stall;

      wr_en   = accept;
      wr_addr = {bank_ff, fill_ff[IDX_W-1:0]};
      wr_data = req_item_value;

      cmd_push     = accept && (reach || req_list_end);
      cmd.bank     = bank_ff;
      cmd.count    = CNT_MAX_W'(count_next);
      cmd.reverse  = reach;
      cmd.list_end = req_list_end;

      fill_in = fill_ff;
      if (accept) begin
         fill_in = cmd_push ? '0 : count_next;
      end
      bank_in = cmd_push ? ~bank_ff : bank_ff;

      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (cmd_push) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gsize_ff <= GSIZE_RESET;
         fill_ff  <= '0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            gsize_ff <= csr_group_size;
         end
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff < CNT_W'(MAX_GROUP))
      else $error("fill count reached group bound without flush");

   a_push_free_bank: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !busy_ff[bank_ff] && !(rel.valid && rel.bank == bank_ff))
      else $error("group flushed from a bank that is still draining");
`endif

endmodule

/* src/kgsr_cmd_queue.sv */
// Two-entry queue of flushed-group commands between front and back ends.
module kgsr_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  kgsr_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              head_valid,
   output kgsr_pkg::cmd_type head_cmd
);
   import kgsr_pkg::*;

   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;

   assign head_valid = cnt_ff != 2'd0;
   assign head_cmd   = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != 2'd2) || pop)
      else $error("command queue overflow");
`endif

endmodule

/* src/kgsr_back.sv */
// Back end: drains one buffered group per command into the result channel.
module kgsr_back #(
   parameter int MAX_GROUP = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  kgsr_pkg::cmd_type                    q_cmd,
   output logic                                 q_pop,
   output kgsr_pkg::release_type                rel,
   output logic                                 rd_en,
   output logic [$clog2(MAX_GROUP):0]           rd_addr,
   input  logic [kgsr_pkg::VALUE_W-1:0]         rd_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [kgsr_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic                                 rsp_run_last,
   output logic                                 rsp_out_list_end
);
   import kgsr_pkg::*;

   localparam int IDX_W = $clog2(MAX_GROUP);
   localparam int CNT_W = $clog2(MAX_GROUP + 1);

   logic             active_ff, bank_ff, rev_ff, end_ff;
   logic [CNT_W-1:0] cnt_ff, idx_ff, pos, last_pos;
   logic             rd_vld_ff, rd_last_ff, rd_end_ff;
   rsp_type          outq_ff [2];
   logic             head_ff, tail_ff;
   logic [1:0]       ocnt_ff, occ;
   logic             pop_out, issue, last_idx, last_issue;

   always_comb begin
      rsp_valid = ocnt_ff != 2'd0;
      pop_out   = rsp_valid && !rsp_stall;
      // Count results already read or queued; keep room for each read.
      occ        = ocnt_ff + 2'(rd_vld_ff);
      issue      = active_ff && ((occ < 2'd2) || pop_out);
      last_pos   = cnt_ff - CNT_W'(1);
      last_idx   = idx_ff == last_pos;
      last_issue = issue && last_idx;
      pos        = rev_ff ? (last_pos - idx_ff) : idx_ff;

      rd_en   = issue;
      rd_addr = {bank_ff, pos[IDX_W-1:0]};

      // Load the next group straight after the last read of this one.
      q_pop     = q_valid && (!active_ff || last_issue);
      rel.valid = last_issue;
      rel.bank  = bank_ff;

      rsp_out_value    = outq_ff[head_ff].value;
      rsp_run_last     = outq_ff[head_ff].run_last;
      rsp_out_list_end = outq_ff[head_ff].list_end;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         bank_ff <= q_cmd.bank;
         cnt_ff  <= q_cmd.count[CNT_W-1:0];
         rev_ff  <= q_cmd.reverse;
         end_ff  <= q_cmd.list_end;
      end
      rd_last_ff <= last_idx;
      rd_end_ff  <= last_idx && end_ff;
      if (rd_vld_ff) begin
         outq_ff[tail_ff] <= '{value: rd_data, run_last: rd_last_ff,
                               list_end: rd_end_ff};
      end
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
         head_ff   <= 1'b0;
         tail_ff   <= 1'b0;
         ocnt_ff   <= '0;
      end else begin
         priority if (q_pop) begin
            active_ff <= 1'b1;
            idx_ff    <= '0;
         end else if (last_issue) begin
            active_ff <= 1'b0;
         end else if (issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         rd_vld_ff <= issue;
         if (rd_vld_ff) begin
            tail_ff <= ~tail_ff;
         end
         if (pop_out) begin
            head_ff <= ~head_ff;
         end
         ocnt_ff <= ocnt_ff + 2'(rd_vld_ff) - 2'(pop_out);
      end
   end

`ifndef ASSERT_OFF
   a_skid_room: assert property (@(posedge clock) disable iff (reset)
      !(ocnt_ff == 2'd2 && rd_vld_ff))
      else $error("read data arrived with no room in output queue");

   a_release_once: assert property (@(posedge clock) disable iff (reset)
      rel.valid |=> !rel.valid || (rel.bank != $past(rel.bank)))
      else $error("same bank released on consecutive cycles");
`endif

endmodule

/* src/k_group_stream_reverser.sv */
// Group-of-k stream reverser: front end, command queue, back end, two-bank buffer.
//
// Elements enter one per cycle, unless req_stall holds them back, into one of
// two buffer banks. When the count reaches group_size (0 or 1 act as 1, values
// above MAX_GROUP act as MAX_GROUP) or the element carries list_end, the bank
// is handed to the back end, which reads it out one result per cycle while the
// result channel has room, reversed for a full group or in arrival order for a
// short tail. While one bank drains the next fills, but a bank comes back to
// the front end only in the cycle after its last read, which stalls the input
// at the start of every second group when the result channel is free. The
// input stalls only when both banks are waiting to drain. Configure group_size
// only while idle.
module k_group_stream_reverser #(
   parameter int MAX_GROUP = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [kgsr_pkg::GSIZE_W-1:0]         csr_group_size,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [kgsr_pkg::VALUE_W-1:0]  req_item_value,
   input  logic                                 req_list_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [kgsr_pkg::VALUE_W-1:0]  rsp_out_value,
   output logic                                 rsp_run_last,
   output logic                                 rsp_out_list_end
);
   import kgsr_pkg::*;

   localparam int ADDR_W = $clog2(MAX_GROUP) + 1;
   localparam int DEPTH  = 2 ** ADDR_W;

   logic               wr_en, rd_en, cmd_push, q_valid, q_pop;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data, rd_data;
   cmd_type            cmd, q_cmd;
   release_type        rel;

   kgsr_front #(.MAX_GROUP(MAX_GROUP)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_group_size   (csr_group_size),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item_value   (req_item_value),
      .req_list_end     (req_list_end),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .cmd_push         (cmd_push),
      .cmd              (cmd),
      .rel              (rel)
   );

   kgsr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_cmd)
   );

   kgsr_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kgsr_back #(.MAX_GROUP(MAX_GROUP)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop),
      .rel              (rel),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_out_list_end (rsp_out_list_end)
   );

endmodule

/* tb/kgsr_checker.sv */
`timescale 1ns / 1ps
// Checker for the k-group stream reverser: predicts the results of each transfer and compares.
module kgsr_checker #(
   parameter int MAX_GROUP = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [kgsr_pkg::GSIZE_W-1:0]   csr_group_size,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [kgsr_pkg::VALUE_W-1:0]   req_item_value,
   input  logic                           req_list_end,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [kgsr_pkg::VALUE_W-1:0]   rsp_out_value,
   input  logic                           rsp_run_last,
   input  logic                           rsp_out_list_end,
   output int                             mismatch_count,
   output int                             pending_count
);

   kgsr_pkg::rsp_type             expected_q[$];
   logic [kgsr_pkg::VALUE_W-1:0]  group_mem [MAX_GROUP];
   logic [kgsr_pkg::GSIZE_W-1:0]  group_size;
   int                            fill;

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %h, expected %h", $time, field, got, want);
      mismatch_count++;
   endtask

   // Buffer one element; flush reversed on a full group, in order on a short tail.
   task automatic predict_item(input logic [31:0] value, input logic last_of_list);
      kgsr_pkg::rsp_type r;
      int                k;
      int                n;
      k = int'(group_size);
      if (k < 1) k = 1;
      if (k > MAX_GROUP) k = MAX_GROUP;
      if (fill >= MAX_GROUP) fill = MAX_GROUP - 1;
      group_mem[fill] = value;
      fill++;
      n = fill;
      if (n >= k) begin
         for (int i = 0; i < n; i++) begin
            r.value    = group_mem[n - 1 - i];
            r.run_last = (i == n - 1);
            r.list_end = (i == n - 1) && last_of_list;
            expected_q.push_back(r);
         end
         fill = 0;
      end else if (last_of_list) begin
         for (int i = 0; i < n; i++) begin
            r.value    = group_mem[i];
            r.run_last = (i == n - 1);
            r.list_end = (i == n - 1);
            expected_q.push_back(r);
         end
         fill = 0;
      end
   endtask

   task automatic check_result();
      kgsr_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         report_mismatch("result with nothing pending, out_value", rsp_out_value, '0);
      end else begin
         want = expected_q.pop_front();
         if (rsp_out_value !== want.value)
            report_mismatch("out_value", rsp_out_value, want.value);
         if (rsp_run_last !== want.run_last)
            report_mismatch("run_last", 32'(rsp_run_last), 32'(want.run_last));
         if (rsp_out_list_end !== want.list_end)
            report_mismatch("out_list_end", 32'(rsp_out_list_end), 32'(want.list_end));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         group_size = kgsr_pkg::GSIZE_RESET;
         fill = 0;
         expected_q.delete();
         mismatch_count = 0;
      end else begin
         if (req_valid && !req_stall) predict_item(req_item_value, req_list_end);
         if (rsp_valid && !rsp_stall) check_result();
         // new size applies from the next transfer on
         if (csr_write_enable) group_size = csr_group_size;
      end
      pending_count <= expected_q.size();
   end

endmodule

/* tb/tb_k_group_stream_reverser.sv */
`timescale 1ns / 1ps
// Testbench top for the k-group stream reverser: clock, reset, stimulus and verdict.
module tb_k_group_stream_reverser;

   localparam int MAX_GROUP  = 16;
   localparam int HOLD_LEN   = 150;
   localparam int CYCLE_LIMIT = 200000;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [kgsr_pkg::GSIZE_W-1:0]        csr_group_size = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [kgsr_pkg::VALUE_W-1:0] req_item_value = '0;
   logic                                req_list_end = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [kgsr_pkg::VALUE_W-1:0] rsp_out_value;
   logic                                rsp_run_last;
   logic                                rsp_out_list_end;

   int   mismatch_count;
   int   pending_count;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;
   logic hold_start = 1'b0;

   k_group_stream_reverser #(
      .MAX_GROUP (MAX_GROUP)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_group_size   (csr_group_size),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item_value   (req_item_value),
      .req_list_end     (req_list_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_out_list_end (rsp_out_list_end)
   );

   kgsr_checker #(
      .MAX_GROUP (MAX_GROUP)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_group_size   (csr_group_size),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item_value   (req_item_value),
      .req_list_end     (req_list_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_out_list_end (rsp_out_list_end),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: random stall, plus one long hold-off to back the block up.
   initial begin
      int remaining;
      bit held;
      remaining = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start && !held) begin
            held = 1'b1;
            remaining = HOLD_LEN;
         end
         if (remaining > 0) begin
            remaining--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input logic [31:0] value, input logic last_of_list);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_item_value <= value;
      req_list_end   <= last_of_list;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, drain every pending result, then cover the pipeline latency.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_group_size(input logic [kgsr_pkg::GSIZE_W-1:0] size);
      csr_write_enable <= 1'b1;
      csr_group_size   <= size;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random(input int budget);
      int sent;
      int len;
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 36);
         for (int i = 0; i < len; i++) send_item(pick_value(), i == len - 1);
         sent += len;
      end
      // leave a partial group behind so the next size meets it
      if ($urandom_range(1) == 1) begin
         len = $urandom_range(1, 5);
         for (int i = 0; i < len; i++) send_item(pick_value(), 1'b0);
      end
   endtask

   initial begin
      logic [kgsr_pkg::GSIZE_W-1:0] size_plan [3][5];
      size_plan = '{'{5'd4, 5'd0, 5'd17, 5'd7, 5'd16},
                    '{5'd1, 5'd31, 5'd3, 5'd12, 5'd2},
                    '{5'd16, 5'd5, 5'd9, 5'd30, 5'd2}};
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset size of two: full pair reversed, then a one-element tail
      send_item(32'h7fff_ffff, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h0000_0000, 1'b1);
      settle();
      // group completed by the final element
      write_group_size(5'd3);
      send_item(32'h0000_0001, 1'b0);
      send_item(32'h0000_0002, 1'b0);
      send_item(32'h0000_0003, 1'b1);
      settle();
      // size zero passes through
      write_group_size(5'd0);
      send_item(32'hffff_ffff, 1'b0);
      send_item(32'h0000_0005, 1'b1);
      settle();
      // oversized: clamps to the largest group
      write_group_size(5'd31);
      for (int i = 0; i < MAX_GROUP; i++)
         send_item(32'h1000_0000 + i, i == MAX_GROUP - 1);
      settle();
      // size lowered with elements already buffered
      write_group_size(5'd8);
      send_item(32'haaaa_aaaa, 1'b0);
      send_item(32'h5555_5555, 1'b0);
      send_item(32'h0f0f_0f0f, 1'b0);
      settle();
      write_group_size(5'd2);
      send_item(32'hf0f0_f0f0, 1'b0);
      settle();

      for (int m = 0; m < 3; m++) begin
         case (m)
            0: begin req_idle_pct = 18; rsp_idle_pct <= 74; end
            1: begin req_idle_pct = 74; rsp_idle_pct <= 18; end
            default: begin req_idle_pct = 0; rsp_idle_pct <= 0; end
         endcase
         for (int s = 0; s < 5; s++) begin
            settle();
            write_group_size(s == 4 ? 5'($urandom_range(31)) : size_plan[m][s]);
            if (m == 2 && s == 0) hold_start <= 1'b1;
            send_random(15);
         end
      end
      send_item(pick_value(), 1'b1);
      settle();

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
